@@ rtl/assert_macros.svh @@
// Assertion macros shared by the odometry RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define POI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define POI_ASSERT_NEXT(label, ante, cons, msg) \
    `POI_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/poi_pkg.sv @@
// Package with constants, types and helper functions of the odometry integrator.
package poi_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int POS_FRAC_BITS = 16;
    localparam int ATAN_COUNT    = 30;
    localparam int STEP_W        = $clog2(ATAN_COUNT);
    localparam int POS_SHIFT     = 36 - POS_FRAC_BITS;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;
    localparam logic signed [31:0] RAD_TO_BAM      = 32'sd683565276;
    localparam logic [22:0]        LIMIT_RESET     = 23'd327680;

    localparam int VEL_W   = 24;
    localparam int DT_W    = 20;
    localparam int LIM_W   = 23;
    localparam int POS_W   = 32;
    localparam int ANG_W   = 32;
    localparam int Q_W     = 16;
    localparam int MA_W    = 38;
    localparam int MB_W    = 32;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = 57;
    localparam int T_W     = 26;
    localparam int DELTA_W = 36;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FOLD = 5'b00010,
        S_ROT  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef logic [3:0] t_mstep;

    localparam t_mstep MS_VX_COS = 4'd0;
    localparam t_mstep MS_VY_SIN = 4'd1;
    localparam t_mstep MS_VX_SIN = 4'd2;
    localparam t_mstep MS_VY_COS = 4'd3;
    localparam t_mstep MS_TX_DT  = 4'd4;
    localparam t_mstep MS_TY_DT  = 4'd5;
    localparam t_mstep MS_VTH_K  = 4'd6;
    localparam t_mstep MS_W_DT   = 4'd7;
    localparam t_mstep MS_YAW    = 4'd8;

    function automatic logic signed [32:0] atan_bam(input logic [STEP_W-1:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0:    v = 33'sd536870912;
            5'd1:    v = 33'sd316933406;
            5'd2:    v = 33'sd167458907;
            5'd3:    v = 33'sd85004756;
            5'd4:    v = 33'sd42667331;
            5'd5:    v = 33'sd21354465;
            5'd6:    v = 33'sd10679838;
            5'd7:    v = 33'sd5340245;
            5'd8:    v = 33'sd2670163;
            5'd9:    v = 33'sd1335087;
            5'd10:   v = 33'sd667544;
            5'd11:   v = 33'sd333772;
            5'd12:   v = 33'sd166886;
            5'd13:   v = 33'sd83443;
            5'd14:   v = 33'sd41722;
            5'd15:   v = 33'sd20861;
            5'd16:   v = 33'sd10430;
            5'd17:   v = 33'sd5215;
            5'd18:   v = 33'sd2608;
            5'd19:   v = 33'sd1304;
            5'd20:   v = 33'sd652;
            5'd21:   v = 33'sd326;
            5'd22:   v = 33'sd163;
            5'd23:   v = 33'sd81;
            5'd24:   v = 33'sd41;
            5'd25:   v = 33'sd20;
            5'd26:   v = 33'sd10;
            5'd27:   v = 33'sd5;
            5'd28:   v = 33'sd3;
            5'd29:   v = 33'sd1;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [VEL_W-1:0] limit_chk(
        input logic signed [VEL_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [VEL_W:0] vv;
        logic signed [VEL_W:0] ll;
        vv = {v[VEL_W-1], v};
        ll = {2'b00, lim};
        if (vv >= ll || vv <= -ll) begin
            return '0;
        end
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0]   acc,
        input logic signed [DELTA_W-1:0] delta
    );
        logic signed [DELTA_W:0] sum;
        sum = (DELTA_W + 1)'(acc) + (DELTA_W + 1)'(delta);
        if (sum > (DELTA_W + 1)'(32'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end
        if (sum < (DELTA_W + 1)'(-33'sh80000000)) begin
            return 32'sh80000000;
        end
        return sum[POS_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] to_q15(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [17:0] q;
        t = 33'(v) + 33'sd16384;
        q = t[32:15];
        if (q > 18'sd32767) begin
            return 16'sh7FFF;
        end
        if (q < -18'sd32768) begin
            return 16'sh8000;
        end
        return q[Q_W-1:0];
    endfunction

endpackage

@@ rtl/planar_odometry_integrator.sv @@
// Planar dead-reckoning odometry integrator built around one iterative CORDIC and one multiplier.
//
// Each accepted beat is a body velocity command and its elapsed time. Forward speed and turn
// rate whose magnitude reaches the speed limit register are replaced by zero. The stored
// heading's sine and cosine come from an iterative CORDIC running one rotation per cycle, and a
// single shared multiplier then performs its products in sequence to rotate the velocity,
// scale it by the elapsed time into the saturating x/y position, and advance the wrapping
// heading. A second CORDIC pass at half the new heading gives the quaternion. A new beat is
// taken only in the idle state, after both CORDIC passes and the multiply sequence of the
// previous beat and its move into the output register. A finished result waits in the
// output register while the next beat is taken. The speed limit may be written at any time.
`include "assert_macros.svh"

module planar_odometry_integrator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [poi_pkg::LIM_W-1:0]            i_cfg_wr_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [poi_pkg::VEL_W-1:0]     i_lin_vel_x,
    input  logic signed [poi_pkg::VEL_W-1:0]     i_lin_vel_y,
    input  logic signed [poi_pkg::VEL_W-1:0]     i_turn_rate,
    input  logic [poi_pkg::DT_W-1:0]             i_elapsed,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [poi_pkg::POS_W-1:0]     o_pose_x,
    output logic signed [poi_pkg::POS_W-1:0]     o_pose_y,
    output logic [poi_pkg::ANG_W-1:0]            o_heading,
    output logic signed [poi_pkg::Q_W-1:0]       o_quat_z,
    output logic signed [poi_pkg::Q_W-1:0]       o_quat_w,
    output logic signed [poi_pkg::VEL_W-1:0]     o_used_vel_x,
    output logic signed [poi_pkg::VEL_W-1:0]     o_used_vel_y,
    output logic signed [poi_pkg::VEL_W-1:0]     o_used_turn_rate
);
    import poi_pkg::*;

    t_state                    r_state, n_state;
    logic                      r_phase, n_phase;
    logic [STEP_W-1:0]         r_i, n_i;
    t_mstep                    r_mstep, n_mstep;
    logic                      r_neg, n_neg;
    logic signed [31:0]        r_x, n_x;
    logic signed [31:0]        r_y, n_y;
    logic signed [32:0]        r_z, n_z;
    logic signed [VEL_W-1:0]   r_vx, n_vx;
    logic signed [VEL_W-1:0]   r_vy, n_vy;
    logic signed [VEL_W-1:0]   r_vth, n_vth;
    logic [DT_W-1:0]           r_dt, n_dt;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [T_W-1:0]     r_tx, n_tx;
    logic signed [T_W-1:0]     r_ty, n_ty;
    logic signed [POS_W-1:0]   r_pos_x, n_pos_x;
    logic signed [POS_W-1:0]   r_pos_y, n_pos_y;
    logic [ANG_W-1:0]          r_yaw, n_yaw;
    logic [LIM_W-1:0]          r_limit, n_limit;
    logic                      r_out_valid, n_out_valid;
    logic signed [POS_W-1:0]   r_out_pose_x, n_out_pose_x;
    logic signed [POS_W-1:0]   r_out_pose_y, n_out_pose_y;
    logic [ANG_W-1:0]          r_out_heading, n_out_heading;
    logic signed [Q_W-1:0]     r_out_quat_z, n_out_quat_z;
    logic signed [Q_W-1:0]     r_out_quat_w, n_out_quat_w;
    logic signed [VEL_W-1:0]   r_out_vx, n_out_vx;
    logic signed [VEL_W-1:0]   r_out_vy, n_out_vy;
    logic signed [VEL_W-1:0]   r_out_vth, n_out_vth;

    logic signed [31:0]        cos_v, sin_v;
    logic signed [31:0]        x_sh, y_sh;
    logic [ANG_W-1:0]          ang;
    logic signed [32:0]        z0;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [ACC_W:0]     dsum;
    logic signed [PROD_W-1:0]  psh;
    logic                      in_fire;

    assign in_fire = i_in_valid && o_in_ready;
    assign cos_v   = r_neg ? -r_x : r_x;
    assign sin_v   = r_neg ? -r_y : r_y;
    assign x_sh    = r_x >>> r_i;
    assign y_sh    = r_y >>> r_i;
    assign ang     = r_phase ? {1'b0, r_yaw[ANG_W-1:1]} : r_yaw;
    assign z0      = {ang[ANG_W-1], ang};
    assign psh     = r_prod >>> POS_SHIFT;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        dsum  = '0;
        case (r_mstep)
            MS_VX_COS: begin
                mul_a = MA_W'(r_vx);
                mul_b = cos_v;
            end
            MS_VY_SIN: begin
                mul_a = MA_W'(r_vy);
                mul_b = sin_v;
            end
            MS_VX_SIN: begin
                mul_a = MA_W'(r_vx);
                mul_b = sin_v;
                dsum  = (ACC_W + 1)'(r_acc) - (ACC_W + 1)'(r_prod[ACC_W-1:0]);
            end
            MS_VY_COS: begin
                mul_a = MA_W'(r_vy);
                mul_b = cos_v;
            end
            MS_TX_DT: begin
                mul_a = MA_W'(r_tx);
                mul_b = MB_W'(r_dt);
                dsum  = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(r_prod[ACC_W-1:0]);
            end
            MS_TY_DT: begin
                mul_a = MA_W'(r_ty);
                mul_b = MB_W'(r_dt);
            end
            MS_VTH_K: begin
                mul_a = MA_W'(r_vth);
                mul_b = RAD_TO_BAM;
            end
            MS_W_DT: begin
                mul_a = r_prod[53:16];
                mul_b = MB_W'(r_dt);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_i           = r_i;
        n_mstep       = r_mstep;
        n_neg         = r_neg;
        n_x           = r_x;
        n_y           = r_y;
        n_z           = r_z;
        n_vx          = r_vx;
        n_vy          = r_vy;
        n_vth         = r_vth;
        n_dt          = r_dt;
        n_prod        = mul_a * mul_b;
        n_acc         = r_acc;
        n_tx          = r_tx;
        n_ty          = r_ty;
        n_pos_x       = r_pos_x;
        n_pos_y       = r_pos_y;
        n_yaw         = r_yaw;
        n_limit       = i_cfg_wr_en ? i_cfg_wr_data : r_limit;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_pose_x  = r_out_pose_x;
        n_out_pose_y  = r_out_pose_y;
        n_out_heading = r_out_heading;
        n_out_quat_z  = r_out_quat_z;
        n_out_quat_w  = r_out_quat_w;
        n_out_vx      = r_out_vx;
        n_out_vy      = r_out_vy;
        n_out_vth     = r_out_vth;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_vx    = limit_chk(i_lin_vel_x, r_limit);
                    n_vy    = i_lin_vel_y;
                    n_vth   = limit_chk(i_turn_rate, r_limit);
                    n_dt    = i_elapsed;
                    n_phase = 1'b0;
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_x   = CORDIC_GAIN_INV;
                n_y   = '0;
                n_i   = '0;
                n_neg = 1'b0;
                n_z   = z0;
                if (z0 > 33'sh40000000) begin
                    n_z   = z0 - 33'sh80000000;
                    n_neg = 1'b1;
                end else if (z0 < -33'sh40000000) begin
                    n_z   = z0 + 33'sh80000000;
                    n_neg = 1'b1;
                end
                n_state = S_ROT;
            end
            S_ROT: begin
                if (!r_z[32]) begin
                    n_x = r_x - y_sh;
                    n_y = r_y + x_sh;
                    n_z = r_z - atan_bam(r_i);
                end else begin
                    n_x = r_x + y_sh;
                    n_y = r_y - x_sh;
                    n_z = r_z + atan_bam(r_i);
                end
                n_i = r_i + 1'b1;
                if (r_i == STEP_LAST) begin
                    n_mstep = MS_VX_COS;
                    n_state = r_phase ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                n_mstep = r_mstep + 1'b1;
                case (r_mstep)
                    MS_VY_SIN: n_acc   = r_prod[ACC_W-1:0];
                    MS_VX_SIN: n_tx    = dsum[55:30];
                    MS_VY_COS: n_acc   = r_prod[ACC_W-1:0];
                    MS_TX_DT:  n_ty    = dsum[55:30];
                    MS_TY_DT:  n_pos_x = sat_add(r_pos_x, psh[DELTA_W-1:0]);
                    MS_VTH_K:  n_pos_y = sat_add(r_pos_y, psh[DELTA_W-1:0]);
                    MS_YAW: begin
                        n_yaw   = r_yaw + r_prod[51:20];
                        n_phase = 1'b1;
                        n_mstep = MS_VX_COS;
                        n_state = S_FOLD;
                    end
                    default: n_acc = r_acc;
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_pose_x  = r_pos_x;
                    n_out_pose_y  = r_pos_y;
                    n_out_heading = r_yaw;
                    n_out_quat_z  = to_q15(sin_v);
                    n_out_quat_w  = to_q15(cos_v);
                    n_out_vx      = r_vx;
                    n_out_vy      = r_vy;
                    n_out_vth     = r_vth;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_i         <= '0;
            r_mstep     <= MS_VX_COS;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_yaw       <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_i         <= n_i;
            r_mstep     <= n_mstep;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_yaw       <= n_yaw;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg         <= n_neg;
        r_x           <= n_x;
        r_y           <= n_y;
        r_z           <= n_z;
        r_vx          <= n_vx;
        r_vy          <= n_vy;
        r_vth         <= n_vth;
        r_dt          <= n_dt;
        r_prod        <= n_prod;
        r_acc         <= n_acc;
        r_tx          <= n_tx;
        r_ty          <= n_ty;
        r_out_pose_x  <= n_out_pose_x;
        r_out_pose_y  <= n_out_pose_y;
        r_out_heading <= n_out_heading;
        r_out_quat_z  <= n_out_quat_z;
        r_out_quat_w  <= n_out_quat_w;
        r_out_vx      <= n_out_vx;
        r_out_vy      <= n_out_vy;
        r_out_vth     <= n_out_vth;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_pose_x         = r_out_pose_x;
    assign o_pose_y         = r_out_pose_y;
    assign o_heading        = r_out_heading;
    assign o_quat_z         = r_out_quat_z;
    assign o_quat_w         = r_out_quat_w;
    assign o_used_vel_x     = r_out_vx;
    assign o_used_vel_y     = r_out_vy;
    assign o_used_turn_rate = r_out_vth;

    `POI_ASSERT(a_state_onehot, $onehot(r_state), "State register is not one-hot.")
    `POI_ASSERT_NEXT(a_accept_starts, in_fire, r_state == S_FOLD && !r_phase, "Pass not started.")
    `POI_ASSERT(a_out_from_done, $rose(r_out_valid) |-> $past(r_state) == S_DONE, "Early result.")
    `POI_ASSERT(a_mstep_range, r_state == S_MUL |-> r_mstep <= MS_YAW, "Bad multiply step.")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the planar odometry integrator with a pose scoreboard.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic signed [poi_pkg::VEL_W-1:0] vel_x;
        logic signed [poi_pkg::VEL_W-1:0] vel_y;
        logic signed [poi_pkg::VEL_W-1:0] turn;
        logic [poi_pkg::DT_W-1:0]         dt;
    } cmd_t;

    typedef struct packed {
        logic signed [poi_pkg::POS_W-1:0] pose_x;
        logic signed [poi_pkg::POS_W-1:0] pose_y;
        logic [poi_pkg::ANG_W-1:0]        heading;
        logic signed [poi_pkg::Q_W-1:0]   quat_z;
        logic signed [poi_pkg::Q_W-1:0]   quat_w;
        logic signed [poi_pkg::VEL_W-1:0] vel_x;
        logic signed [poi_pkg::VEL_W-1:0] vel_y;
        logic signed [poi_pkg::VEL_W-1:0] turn;
    } pose_t;

    localparam longint HALF_GAIN_Q30  = 652032874;
    localparam longint BAM_PER_RAD    = 683565276;
    localparam longint POS_HIGH       = 64'sd2147483647;
    localparam longint POS_LOW        = -64'sd2147483648;
    localparam logic [22:0] LIMIT_RST = 23'd327680;
    localparam logic [22:0] LIMIT_MAX = 23'h7FFFFF;
    localparam int HOLD_CYCLES        = 300;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int END_DRAIN          = 100;

    localparam longint ATAN_STEP [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1
    };

    class pose_scoreboard;
        logic [22:0] limit;
        longint      pos_x;
        longint      pos_y;
        logic [31:0] yaw;
        pose_t       expected_poses[$];
        int          errors;
        int          checked;

        function new();
            limit   = LIMIT_RST;
            pos_x   = 0;
            pos_y   = 0;
            yaw     = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function longint gate_speed(logic signed [23:0] v);
            longint lv;
            longint lim;
            lv  = longint'(v);
            lim = longint'({1'b0, limit});
            if (lv >= lim || lv <= -lim) begin
                return 0;
            end
            return lv;
        endfunction

        function void sin_cos(input logic [31:0] ang, output longint c, output longint s);
            longint z;
            longint x;
            longint y;
            longint nx;
            bit     flip;
            z    = ang[31] ? longint'({32'd0, ang}) - 64'sh1_0000_0000 : longint'({32'd0, ang});
            x    = HALF_GAIN_Q30;
            y    = 0;
            flip = 1'b0;
            if (z > 64'sh4000_0000) begin
                z    = z - 64'sh8000_0000;
                flip = 1'b1;
            end else if (z < -64'sh4000_0000) begin
                z    = z + 64'sh8000_0000;
                flip = 1'b1;
            end
            for (int i = 0; i < poi_pkg::CORDIC_STEPS && i < 30; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ATAN_STEP[i];
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ATAN_STEP[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint clamp_pos(longint v);
            if (v > POS_HIGH) begin
                return POS_HIGH;
            end
            if (v < POS_LOW) begin
                return POS_LOW;
            end
            return v;
        endfunction

        function logic signed [15:0] round_q15(longint v);
            longint q;
            q = (v + 16384) >>> 15;
            if (q > 32767) begin
                return 16'sh7FFF;
            end
            if (q < -32768) begin
                return 16'sh8000;
            end
            return q[15:0];
        endfunction

        function void note_command(cmd_t cmd);
            longint vx;
            longint vy;
            longint vth;
            longint dt;
            longint c;
            longint s;
            longint tx;
            longint ty;
            longint w;
            longint dth;
            longint qc;
            longint qs;
            pose_t  p;
            vx  = gate_speed(cmd.vel_x);
            vy  = longint'(cmd.vel_y);
            vth = gate_speed(cmd.turn);
            dt  = longint'({44'd0, cmd.dt});
            sin_cos(yaw, c, s);
            tx    = (vx * c - vy * s) >>> 30;
            ty    = (vx * s + vy * c) >>> 30;
            pos_x = clamp_pos(pos_x + ((tx * dt) >>> (36 - poi_pkg::POS_FRAC_BITS)));
            pos_y = clamp_pos(pos_y + ((ty * dt) >>> (36 - poi_pkg::POS_FRAC_BITS)));
            w     = (vth * BAM_PER_RAD) >>> 16;
            dth   = (w * dt) >>> 20;
            yaw   = yaw + dth[31:0];
            sin_cos({1'b0, yaw[31:1]}, qc, qs);
            p.pose_x  = pos_x[31:0];
            p.pose_y  = pos_y[31:0];
            p.heading = yaw;
            p.quat_z  = round_q15(qs);
            p.quat_w  = round_q15(qc);
            p.vel_x   = vx[23:0];
            p.vel_y   = vy[23:0];
            p.turn    = vth[23:0];
            expected_poses.push_back(p);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pose(pose_t got);
            pose_t want;
            if (expected_poses.size() == 0) begin
                $error("pose beat arrived with no command outstanding");
                errors++;
                return;
            end
            want = expected_poses.pop_front();
            checked++;
            compare_field("pose_x", want.pose_x, got.pose_x);
            compare_field("pose_y", want.pose_y, got.pose_y);
            compare_field("heading", want.heading, got.heading);
            compare_field("quat_z", want.quat_z, got.quat_z);
            compare_field("quat_w", want.quat_w, got.quat_w);
            compare_field("used_vel_x", want.vel_x, got.vel_x);
            compare_field("used_vel_y", want.vel_y, got.vel_y);
            compare_field("used_turn_rate", want.turn, got.turn);
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction
    endclass

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_wr_en   = 1'b0;
    logic [poi_pkg::LIM_W-1:0]         i_cfg_wr_data = '0;
    logic                              i_in_valid    = 1'b0;
    logic                              o_in_ready;
    logic signed [poi_pkg::VEL_W-1:0]  i_lin_vel_x   = '0;
    logic signed [poi_pkg::VEL_W-1:0]  i_lin_vel_y   = '0;
    logic signed [poi_pkg::VEL_W-1:0]  i_turn_rate   = '0;
    logic [poi_pkg::DT_W-1:0]          i_elapsed     = '0;
    logic                              o_out_valid;
    logic                              i_out_ready   = 1'b0;
    logic signed [poi_pkg::POS_W-1:0]  o_pose_x;
    logic signed [poi_pkg::POS_W-1:0]  o_pose_y;
    logic [poi_pkg::ANG_W-1:0]         o_heading;
    logic signed [poi_pkg::Q_W-1:0]    o_quat_z;
    logic signed [poi_pkg::Q_W-1:0]    o_quat_w;
    logic signed [poi_pkg::VEL_W-1:0]  o_used_vel_x;
    logic signed [poi_pkg::VEL_W-1:0]  o_used_vel_y;
    logic signed [poi_pkg::VEL_W-1:0]  o_used_turn_rate;

    pose_scoreboard sb;
    pose_t          seen_pose;
    int             send_idle_pct = 35;
    int             recv_idle_pct = 58;
    int             hold_req      = 0;
    int             hold_ack      = 0;
    int             hold_left     = 0;
    int             quiet_cycles  = 0;
    int             commands_sent = 0;

    planar_odometry_integrator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_lin_vel_x      (i_lin_vel_x),
        .i_lin_vel_y      (i_lin_vel_y),
        .i_turn_rate      (i_turn_rate),
        .i_elapsed        (i_elapsed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pose_x         (o_pose_x),
        .o_pose_y         (o_pose_y),
        .o_heading        (o_heading),
        .o_quat_z         (o_quat_z),
        .o_quat_w         (o_quat_w),
        .o_used_vel_x     (o_used_vel_x),
        .o_used_vel_y     (o_used_vel_y),
        .o_used_turn_rate (o_used_turn_rate)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen_pose.pose_x  = o_pose_x;
                seen_pose.pose_y  = o_pose_y;
                seen_pose.heading = o_heading;
                seen_pose.quat_z  = o_quat_z;
                seen_pose.quat_w  = o_quat_w;
                seen_pose.vel_x   = o_used_vel_x;
                seen_pose.vel_y   = o_used_vel_y;
                seen_pose.turn    = o_used_turn_rate;
                sb.check_pose(seen_pose);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req != hold_ack) begin
                hold_ack++;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_cmd(
        input logic signed [23:0] vx,
        input logic signed [23:0] vy,
        input logic signed [23:0] vth,
        input logic [19:0]        dt
    );
        cmd_t c;
        c.vel_x = vx;
        c.vel_y = vy;
        c.turn  = vth;
        c.dt    = dt;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_lin_vel_x <= c.vel_x;
        i_lin_vel_y <= c.vel_y;
        i_turn_rate <= c.turn;
        i_elapsed   <= c.dt;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.note_command(c);
        commands_sent++;
    endtask

    task automatic write_limit(input logic [22:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        sb.limit = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [23:0] random_speed(input logic [22:0] lim);
        int               sel;
        logic signed [23:0] mag;
        sel = $urandom_range(99);
        if (sel < 10) begin
            mag = {1'b0, lim};
        end else if (sel < 20) begin
            mag = {1'b0, lim} - 24'sd1;
        end else if (sel < 35) begin
            return 24'($urandom);
        end else if (sel < 40 || lim < 2) begin
            mag = '0;
        end else begin
            mag = 24'($urandom_range(lim - 1));
        end
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic logic [19:0] random_elapsed();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) begin
            return '0;
        end
        if (sel < 15) begin
            return 20'hFFFFF;
        end
        return 20'($urandom);
    endfunction

    initial begin
        int                 seg_items [0:5];
        logic [22:0]        seg_limit;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vth;
        logic signed [23:0] mag;
        logic [19:0]        dt;
        bit                 sx;
        bit                 sy;

        seg_items = '{45, 45, 45, 25, 40, 300};
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset value of the speed limit is exercised before any write.
        send_cmd(24'sd0, 24'sd0, 24'sd0, 20'd0);
        send_cmd(24'sd327679, 24'sd0, 24'sd327679, 20'hFFFFF);
        send_cmd(24'sd327680, 24'sd8388607, -24'sd327680, 20'hFFFFF);
        send_cmd(-24'sd327679, 24'sh800000, -24'sd327679, 20'd1);
        send_cmd(24'sd8388607, 24'sd0, 24'sh800000, 20'hFFFFF);
        send_cmd(24'sh800000, 24'sd1000, 24'sd8388607, 20'd524288);
        repeat (6) send_cmd(24'sd200000, -24'sd100000, 24'sd327679, 20'hFFFFF);
        repeat (2) send_cmd(-24'sd150000, 24'sd90000, -24'sd300000, 20'hFFFFF);

        write_limit(23'd0);
        send_cmd(24'sd1, 24'sd5000, -24'sd1, 20'hFFFFF);
        send_cmd(-24'sd1, -24'sd5000, 24'sd1, 20'd777);

        write_limit(LIMIT_MAX);
        send_cmd(24'sd8388606, 24'sd8388607, 24'sd8388606, 20'hFFFFF);
        send_cmd(-24'sd8388607, 24'sh800000, -24'sd8388607, 20'hFFFFF);
        send_cmd(24'sd8388607, 24'sd123456, 24'sh800000, 20'hFFFFF);
        send_cmd(24'sh800000, -24'sd123456, 24'sd8388607, 20'd1);

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: seg_limit = LIMIT_RST;
                1: seg_limit = 23'($urandom_range(8388607));
                2: seg_limit = 23'd1;
                3: seg_limit = 23'($urandom_range(1048576, 65536));
                4: seg_limit = 23'($urandom_range(8388607));
                default: seg_limit = LIMIT_MAX;
            endcase
            write_limit(seg_limit);
            case (seg / 2)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sx = $urandom_range(1);
            sy = $urandom_range(1);
            for (int k = 0; k < seg_items[seg]; k++) begin
                if (seg == 4 && k == 10) begin
                    hold_req++;
                end
                if (seg == 5 && $urandom_range(9) != 0) begin
                    // A long straight run at full speed drives the position into saturation.
                    mag = 24'sd8388606 - 24'($urandom_range(2000));
                    vx  = sx ? -mag : mag;
                    mag = 24'sd8388607 - 24'($urandom_range(2000));
                    vy  = sy ? -mag : mag;
                    case ($urandom_range(2))
                        0: vth = 24'sd0;
                        1: vth = 24'sd8388607;
                        default: vth = 24'sh800000;
                    endcase
                    dt = 20'hFFFFF - 20'($urandom_range(1000));
                end else begin
                    vx  = random_speed(seg_limit);
                    vy  = $urandom_range(1) ? 24'($urandom) : random_speed(seg_limit);
                    vth = random_speed(seg_limit);
                    dt  = random_elapsed();
                end
                send_cmd(vx, vy, vth, dt);
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_DRAIN) @(posedge i_clk);

        $display("summary: %0d velocity commands, %0d poses checked, speed limits zero to full scale",
                 commands_sent, sb.checked);
        $display("summary: idle mixes on both sides, a %0d-cycle output hold-off, a straight run",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
